FILE: rtl/clcd_pkg.sv
`default_nettype none
package clcd_pkg;

  // Request codes carried on the input tuser
  localparam logic [1:0] CMD_INIT = 2'd0;
  localparam logic [1:0] CMD_CMD  = 2'd1;
  localparam logic [1:0] CMD_DATA = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TWO_LINES  = 2'd0;
  localparam logic [1:0] CFG_BIG_FONT   = 2'd1;
  localparam logic [1:0] CFG_ADDR_INC   = 2'd2;
  localparam logic [1:0] CFG_DISP_SHIFT = 2'd3;

  // Hold times in microseconds
  localparam logic [15:0] HOLD_POWERUP = 16'd50000;
  localparam logic [15:0] HOLD_STROBE  = 16'd1;
  localparam logic [15:0] HOLD_SETTLE  = 16'd100;
  localparam logic [15:0] DELAY_SHORT  = 16'd100;
  localparam logic [15:0] DELAY_LONG   = 16'd3000;
  localparam logic [15:0] EXTRA_FIRST  = 16'd5000;
  localparam logic [15:0] EXTRA_NEXT   = 16'd1000;

  // Nibble jobs: init runs four upper-only nibbles, then five full bytes
  localparam logic [3:0] JOB_UPPER_CNT = 4'd4;
  localparam logic [3:0] JOB_LAST_INIT = 4'd13;
  localparam logic [3:0] JOB_LAST_BYTE = 4'd1;
  localparam logic [3:0] JOB_UPPER_TWO = 4'd3;

  localparam logic [1:0] PH_SETUP  = 2'd0;
  localparam logic [1:0] PH_STROBE = 2'd1;
  localparam logic [1:0] PH_SETTLE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POWER,
    ST_NIB
  } seq_state_t;

  typedef struct packed {
    logic two_lines;
    logic big_font;
    logic addr_inc;
    logic disp_shift;
  } cfg_t;

  // One pin state as shown on the result channel
  typedef struct packed {
    logic        last;
    logic [15:0] hold_us;
    logic [3:0]  nibble;
    logic        enable;
    logic        read_write;
    logic        reg_select;
  } pin_state_t;

  // Request into the hold-time unit
  typedef struct packed {
    logic       powerup;
    logic       settle;
    logic       upper_only;
    logic       upper_first;
    logic       lo;
    logic       rs;
    logic [7:0] byte_val;
  } hold_req_t;

  // Full command bytes sent after the upper-only nibbles of init
  function automatic logic [7:0] init_byte(input logic [2:0] idx, input cfg_t cfg);
    logic [7:0] b;
    begin
      case (idx)
        3'd0:    b = {4'h2, cfg.two_lines, cfg.big_font, 2'b00};
        3'd1:    b = 8'h08;
        3'd2:    b = 8'h01;
        3'd3:    b = {6'b000001, cfg.addr_inc, cfg.disp_shift};
        default: b = 8'h0C;
      endcase
      return b;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/clcd_hold_unit.sv
`default_nettype none
module clcd_hold_unit (
  input  clcd_pkg::hold_req_t req,
  output logic [15:0]         hold_us
);
  import clcd_pkg::*;

  logic        is_clr_home;
  logic [15:0] extra;
  logic [15:0] base;
  logic [15:0] addend;

  // Range compare for clear / home commands, then one shared add
  always_comb begin
    is_clr_home = !req.rs && (req.byte_val >= 8'h01) && (req.byte_val <= 8'h03);
    if (req.upper_only) begin
      extra = req.upper_first ? EXTRA_FIRST : EXTRA_NEXT;
    end else if (req.lo) begin
      extra = is_clr_home ? DELAY_LONG : DELAY_SHORT;
    end else begin
      extra = '0;
    end
    if (req.powerup) begin
      base = HOLD_POWERUP;
    end else if (req.settle) begin
      base = HOLD_SETTLE;
    end else begin
      base = HOLD_STROBE;
    end
    addend  = (req.settle && !req.powerup) ? extra : '0;
    hold_us = base + addend;
  end

endmodule
`default_nettype wire

FILE: rtl/clcd_seq.sv
`default_nettype none
module clcd_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           cmd,
  input  logic [7:0]           value,
  input  clcd_pkg::cfg_t       cfg,
  input  logic                 adv,
  output logic                 ready,
  output logic                 emit,
  output clcd_pkg::pin_state_t pin
);
  import clcd_pkg::*;

  seq_state_t st_r, st_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] job_r, job_nxt;
  logic       init_r, init_nxt;
  logic       rs_r, rs_nxt;
  logic [7:0] value_r, value_nxt;

  logic [3:0] job_off;
  logic [7:0] cur_byte;
  logic       upper;
  logic       lo;
  logic       last_job;
  logic [3:0] cur_nib;
  hold_req_t  req;
  logic [15:0] hold_us;

  clcd_hold_unit u_hold (
    .req     (req),
    .hold_us (hold_us)
  );

  // Current nibble job decode
  always_comb begin
    job_off  = job_r - JOB_UPPER_CNT;
    cur_byte = init_r ? init_byte(job_off[3:1], cfg) : value_r;
    upper    = init_r && (job_r < JOB_UPPER_CNT);
    lo       = job_r[0];
    last_job = init_r ? (job_r == JOB_LAST_INIT) : (job_r == JOB_LAST_BYTE);
    if (upper) begin
      cur_nib = (job_r == JOB_UPPER_TWO) ? 4'h2 : 4'h3;
    end else begin
      cur_nib = lo ? cur_byte[3:0] : cur_byte[7:4];
    end
  end

  // Request to the shared hold unit
  always_comb begin
    req.powerup     = (st_r == ST_POWER);
    req.settle      = (phase_r == PH_SETTLE);
    req.upper_only  = upper;
    req.upper_first = (job_r == '0);
    req.lo          = lo;
    req.rs          = rs_r;
    req.byte_val    = cur_byte;
  end

  // Next state and pin state
  always_comb begin
    st_nxt    = st_r;
    phase_nxt = phase_r;
    job_nxt   = job_r;
    init_nxt  = init_r;
    rs_nxt    = rs_r;
    value_nxt = value_r;
    ready     = 1'b0;
    emit      = 1'b0;
    pin.reg_select = rs_r;
    pin.read_write = 1'b0;
    pin.enable     = (phase_r == PH_STROBE);
    pin.nibble     = cur_nib;
    pin.hold_us    = hold_us;
    pin.last       = (phase_r == PH_SETTLE) && last_job;
    unique case (st_r)
      ST_IDLE: begin
        ready = 1'b1;
        if (start) begin
          phase_nxt = PH_SETUP;
          job_nxt   = '0;
          value_nxt = value;
          case (cmd)
            CMD_INIT: begin
              init_nxt = 1'b1;
              rs_nxt   = 1'b0;
              st_nxt   = ST_POWER;
            end
            CMD_CMD: begin
              init_nxt = 1'b0;
              rs_nxt   = 1'b0;
              st_nxt   = ST_NIB;
            end
            CMD_DATA: begin
              init_nxt = 1'b0;
              rs_nxt   = 1'b1;
              st_nxt   = ST_NIB;
            end
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_POWER: begin
        pin.reg_select = 1'b0;
        pin.enable     = 1'b0;
        pin.nibble     = '0;
        pin.last       = 1'b0;
        emit           = adv;
        if (adv) begin
          st_nxt    = ST_NIB;
          phase_nxt = PH_SETUP;
          job_nxt   = '0;
        end
      end
      ST_NIB: begin
        emit = adv;
        if (adv) begin
          if (phase_r == PH_SETTLE) begin
            phase_nxt = PH_SETUP;
            if (last_job) begin
              st_nxt = ST_IDLE;
            end else begin
              job_nxt = job_r + 4'd1;
            end
          end else begin
            phase_nxt = phase_r + 2'd1;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    job_r   <= job_nxt;
    init_r  <= init_nxt;
    rs_r    <= rs_nxt;
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/char_lcd_nibble_write_sequencer_core.sv
`default_nettype none
// Channel | Dir | Ports                          | Carries
// in      | in  | in_tvalid/tready/tdata/tuser   | tdata: value; tuser: command
// out     | out | out_tvalid/tready/tdata/tlast  | one pin state per item
// cfg     | in  | cfg_we/cfg_addr/cfg_wdata      | 1-bit setup registers
//
// A byte write gives 6 pin states, init gives 43; the sequencer emits one
// state per cycle through the output register while the output is not stalled.
// in_tready is high only while the sequencer is idle.
// Output stalls freeze the sequencer; a taken item frees the register at once.
// Reset is synchronous, active low, and leaves the block idle.
module char_lcd_nibble_write_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] value
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] reg_select, [1] read_write, [2] enable,
                                  // [6:3] nibble, [22:7] hold_us, [23] zero
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic        cfg_wdata
);
  import clcd_pkg::*;

  cfg_t       cfg_r;
  logic       out_valid_r, out_valid_nxt;
  pin_state_t out_pin_r;
  logic       adv;
  logic       emit;
  logic       seq_ready;
  pin_state_t pin;

  // Setup registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{two_lines: 1'b1, big_font: 1'b0, addr_inc: 1'b1, disp_shift: 1'b1};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TWO_LINES:  cfg_r.two_lines  <= cfg_wdata;
        CFG_BIG_FONT:   cfg_r.big_font   <= cfg_wdata;
        CFG_ADDR_INC:   cfg_r.addr_inc   <= cfg_wdata;
        CFG_DISP_SHIFT: cfg_r.disp_shift <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = seq_ready;

  clcd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_tvalid && seq_ready),
    .cmd   (in_tuser),
    .value (in_tdata),
    .cfg   (cfg_r),
    .adv   (adv),
    .ready (seq_ready),
    .emit  (emit),
    .pin   (pin)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pin_r <= pin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pin_r.hold_us, out_pin_r.nibble, out_pin_r.enable,
                       out_pin_r.read_write, out_pin_r.reg_select};
  assign out_tlast  = out_pin_r.last;

endmodule
`default_nettype wire

FILE: rtl/clcd_checker.sv
`default_nettype none
module clcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);
  import clcd_pkg::*;

  // Stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output item changed");

  // A taken valid request closes the input
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_INIT || in_tuser == CMD_CMD ||
                               in_tuser == CMD_DATA) |=> !in_tready)
    else $error("input accepted during a run");

  // Writes only: RW stays low
  a_rw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[1])
    else $error("read_write high");

  // Strobe states hold for one microsecond and never end a run
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[22:7] == HOLD_STROBE && !out_tlast)
    else $error("bad strobe state");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind char_lcd_nibble_write_sequencer_core clcd_checker u_clcd_checker (.*);
`default_nettype wire
